/* rtl/clas_pkg.sv */
// shared types and constants for the command line argument splitter
package clas_pkg;

    localparam int CHAR_W   = 8;
    localparam int NUM_W    = 7;
    localparam int CNT_W    = 8;
    localparam int REP_W    = 10;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CHAR_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;

    localparam logic [REP_W-1:0] REPEAT_MAX = 10'h3FF;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_LIMIT   = 8'd1;

    localparam logic [NUM_W-1:0] FIRST_INDEX_RESET = 7'd1;
    localparam logic [CNT_W-1:0] ARG_LIMIT_RESET   = 8'd100;

    typedef struct packed {
        logic [REP_W-1:0]  slash_repeat;
        logic              char_valid;
        logic [CHAR_W-1:0] char_out;
        logic              arg_end;
        logic [NUM_W-1:0]  arg_number;
        logic              limit_hit;
        logic              stream_done;
    } clas_result_t;

endpackage

/* rtl/clas_in_if.sv */
// byte channel into the argument splitter
interface clas_in_if;
    logic                        valid;
    logic                        ready;
    logic [clas_pkg::CHAR_W-1:0] char_in;
    logic                        last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

/* rtl/clas_out_if.sv */
// result channel out of the argument splitter
interface clas_out_if;
    logic                        valid;
    logic                        ready;
    logic [clas_pkg::REP_W-1:0]  slash_repeat;
    logic                        char_valid;
    logic [clas_pkg::CHAR_W-1:0] char_out;
    logic                        arg_end;
    logic [clas_pkg::NUM_W-1:0]  arg_number;
    logic                        limit_hit;
    logic                        stream_done;

    modport source (
        output valid, output slash_repeat, output char_valid, output char_out,
        output arg_end, output arg_number, output limit_hit, output stream_done,
        input ready
    );
    modport sink (
        input valid, input slash_repeat, input char_valid, input char_out,
        input arg_end, input arg_number, input limit_hit, input stream_done,
        output ready
    );
endinterface

/* rtl/clas_cfg_if.sv */
// register write channel of the argument splitter
interface clas_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [clas_pkg::CFG_IDX_W-1:0]  index;
    logic [clas_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/command_line_argument_splitter_unit.sv */
// top level of the command line argument splitter
// Takes one command-line byte per cycle while the result channel is not stalled,
// and offers at most one result word per clock. A byte is held in the input
// register; its result, if it has one, is then loaded into the result register
// and offered from there on the result channel. A stalled result channel
// holds the result register and, through it, the input register.
// The per-byte state update (quote mode, counted backslash run, argument
// counter, limit flag) is a single combinational step between those registers.
// Bytes that produce nothing are consumed without a result word.
module command_line_argument_splitter_unit #(
    parameter int MAX_ARGS_P = 128,
    parameter int RUN_MAX    = 1023
) (
    input  logic       clk,
    input  logic       rst_n,
    clas_in_if.sink    cmd,
    clas_out_if.source arg,
    clas_cfg_if.sink   cfg
);

    logic [clas_pkg::NUM_W-1:0]  first_index_reg;
    logic [clas_pkg::CNT_W-1:0]  arg_limit_reg;

    logic                        s1_valid_reg;
    logic [clas_pkg::CHAR_W-1:0] s1_char_reg;
    logic                        s1_last_reg;

    logic                        out_valid_reg;
    clas_pkg::clas_result_t      out_reg;

    logic                        out_free;
    logic                        s1_fire;
    logic                        emit;
    clas_pkg::clas_result_t      result;

    assign out_free  = !out_valid_reg || arg.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_index_reg <= clas_pkg::FIRST_INDEX_RESET;
            arg_limit_reg   <= clas_pkg::ARG_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == clas_pkg::CFG_FIRST_INDEX)
                first_index_reg <= cfg.data[clas_pkg::NUM_W-1:0];
            else if (cfg.index == clas_pkg::CFG_ARG_LIMIT)
                arg_limit_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cmd.ready)
            s1_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            s1_char_reg <= cmd.char_in;
            s1_last_reg <= cmd.last_in;
        end
    end

    clas_core #(
        .MAX_ARGS_P (MAX_ARGS_P),
        .RUN_MAX    (RUN_MAX)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .char_in     (s1_char_reg),
        .last_in     (s1_last_reg),
        .first_index (first_index_reg),
        .arg_limit   (arg_limit_reg),
        .emit        (emit),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= emit;
        else if (arg.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
            out_reg <= result;
    end

    assign arg.valid        = out_valid_reg;
    assign arg.slash_repeat = out_reg.slash_repeat;
    assign arg.char_valid   = out_reg.char_valid;
    assign arg.char_out     = out_reg.char_out;
    assign arg.arg_end      = out_reg.arg_end;
    assign arg.arg_number   = out_reg.arg_number;
    assign arg.limit_hit    = out_reg.limit_hit;
    assign arg.stream_done  = out_reg.stream_done;

endmodule

/* rtl/clas_core.sv */
// splitter state and the per-byte update logic
module clas_core #(
    parameter int MAX_ARGS_P = 128,
    parameter int RUN_MAX    = 1023
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [clas_pkg::CHAR_W-1:0]   char_in,
    input  logic                          last_in,
    input  logic [clas_pkg::NUM_W-1:0]    first_index,
    input  logic [clas_pkg::CNT_W-1:0]    arg_limit,
    output logic                          emit,
    output clas_pkg::clas_result_t        result
);

    localparam int RUN_W = $clog2(RUN_MAX + 1);
    localparam logic [RUN_W-1:0] RUN_TOP = RUN_W'(RUN_MAX);

    logic                          quoted_reg, quoted_next;
    logic [RUN_W-1:0]              run_reg, run_next;
    logic                          has_data_reg, has_data_next;
    logic [clas_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          stopped_reg, stopped_next;
    logic                          line_start_reg;

    logic [clas_pkg::CNT_W-1:0]    cnt_cur;
    logic [clas_pkg::CNT_W-1:0]    cnt_inc;
    logic [RUN_W-1:0]              rep;
    logic                          chr_valid;
    logic [clas_pkg::CHAR_W-1:0]   chr;
    logic                          close;
    logic                          is_blank;

    always_comb
    begin
        cnt_cur = line_start_reg ? {1'b0, first_index} : cnt_reg;
        cnt_inc = cnt_cur + 1'b1;
        is_blank = (char_in == clas_pkg::CHAR_SPACE)
                || ((char_in >= clas_pkg::CHAR_TAB) && (char_in <= clas_pkg::CHAR_CR));

        quoted_next   = quoted_reg;
        run_next      = run_reg;
        has_data_next = has_data_reg;
        rep           = '0;
        chr_valid     = 1'b0;
        chr           = '0;
        close         = 1'b0;

        if (!stopped_reg)
        begin
            priority if (char_in == clas_pkg::CHAR_BSLASH)
            begin
                if (run_reg != RUN_TOP)
                    run_next = run_reg + 1'b1;
            end
            else if (char_in == clas_pkg::CHAR_DQUOTE)
            begin
                rep       = run_reg >> 1;
                chr_valid = run_reg[0];
                if (run_reg[0])
                    chr = clas_pkg::CHAR_DQUOTE;
                else
                    quoted_next = ~quoted_reg;
                if (run_reg > RUN_W'(1))
                    has_data_next = 1'b1;
                if (run_reg[0])
                    has_data_next = 1'b1;
                run_next = '0;
            end
            else if (is_blank && !quoted_reg)
            begin
                rep = run_reg;
                if (run_reg != '0)
                    has_data_next = 1'b1;
                run_next = '0;
                if (has_data_next)
                begin
                    close         = 1'b1;
                    has_data_next = 1'b0;
                end
            end
            else
            begin
                rep           = run_reg;
                chr_valid     = 1'b1;
                chr           = char_in;
                has_data_next = 1'b1;
                run_next      = '0;
            end

            if (last_in)
            begin
                if (run_next != '0)
                begin
                    rep           = run_next;
                    has_data_next = 1'b1;
                    run_next      = '0;
                end
                if (has_data_next)
                begin
                    close         = 1'b1;
                    has_data_next = 1'b0;
                end
            end
        end

        cnt_next     = close ? cnt_inc : cnt_cur;
        stopped_next = stopped_reg
                    | (close && ((cnt_inc >= arg_limit)
                              || (32'(cnt_inc) >= 32'(MAX_ARGS_P))));

        emit = (rep != '0) || chr_valid || close || last_in;

        if (32'(rep) > 32'(clas_pkg::REPEAT_MAX))
            result.slash_repeat = clas_pkg::REPEAT_MAX;
        else
            result.slash_repeat = clas_pkg::REP_W'(rep);
        result.char_valid  = chr_valid;
        result.char_out    = chr;
        result.arg_end     = close;
        result.arg_number  = cnt_cur[clas_pkg::NUM_W-1:0];
        result.limit_hit   = stopped_next;
        result.stream_done = last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg     <= 1'b0;
            run_reg        <= '0;
            has_data_reg   <= 1'b0;
            cnt_reg        <= {1'b0, clas_pkg::FIRST_INDEX_RESET};
            stopped_reg    <= 1'b0;
            line_start_reg <= 1'b1;
        end
        else if (fire)
        begin
            if (last_in)
            begin
                quoted_reg     <= 1'b0;
                run_reg        <= '0;
                has_data_reg   <= 1'b0;
                cnt_reg        <= {1'b0, first_index};
                stopped_reg    <= 1'b0;
                line_start_reg <= 1'b1;
            end
            else
            begin
                quoted_reg     <= quoted_next;
                run_reg        <= run_next;
                has_data_reg   <= has_data_next;
                cnt_reg        <= cnt_next;
                stopped_reg    <= stopped_next;
                line_start_reg <= 1'b0;
            end
        end
    end

endmodule
